### sv/sbs_pkg.sv
// Shared constants, codes and saturating helpers for the seven-band SOR solver.
// No dependencies.
`timescale 1ns / 1ps

package sbs_pkg;

  localparam int MAX_ROWS_DEF  = 256;
  localparam int FRAC_BITS_DEF = 16;
  localparam int RELAX_FRAC    = 16;
  localparam int DATA_W        = 32;
  localparam int CFG_IDX_W     = 3;
  localparam int MODE_W        = 2;
  localparam int ROW_W         = 8;
  localparam int SLOTS         = 8;

  // request modes
  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SOLVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SIZE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAXIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RELAX = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TOL   = 3'd5;

  // coefficient word slots, in row-sum order; rhs last
  localparam int SLOT_MAIN = 3;
  localparam int SLOT_RHS  = 7;

  localparam logic signed [63:0] SAT64 = 64'sh7FFF_FFFF_FFFF_FFFF;

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return SAT64;
    if (s < -65'sh0_7FFF_FFFF_FFFF_FFFF) return -SAT64;
    return s[63:0];
  endfunction

  function automatic logic [63:0] usat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [65:0] v);
    if (v > 66'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -66'sh0_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

endpackage

### sv/sbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/seven_band_sor_solver_top.sv
// Load and read requests give one result each. Solve clears the solution store, then runs
// a residual check and, until it converges, reaches max_iterations or meets a zero
// diagonal, a sweep over the rows; a sweep divides with the 64-step divider and multiplies
// on the shared multiplier. One request at a time. After reset the solution store is
// cleared before a request is taken.
// Depends on sbs_pkg and sbs_ram.
`timescale 1ns / 1ps

module seven_band_sor_solver_top #(
  parameter int MAX_ROWS  = sbs_pkg::MAX_ROWS_DEF,
  parameter int FRAC_BITS = sbs_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [sbs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sbs_pkg::DATA_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [sbs_pkg::MODE_W-1:0]          mode,
  input  logic [sbs_pkg::ROW_W-1:0]           row,
  input  logic signed [31:0]                  main_coef,
  input  logic signed [31:0]                  near_low_coef,
  input  logic signed [31:0]                  mid_low_coef,
  input  logic signed [31:0]                  far_low_coef,
  input  logic signed [31:0]                  near_up_coef,
  input  logic signed [31:0]                  mid_up_coef,
  input  logic signed [31:0]                  far_up_coef,
  input  logic signed [31:0]                  rhs_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [31:0]                  x_value,
  output logic [15:0]                         sweeps_done,
  output logic                                converged,
  output logic                                zero_pivot
);

  localparam int AW  = $clog2(MAX_ROWS);
  localparam int NW  = $clog2(MAX_ROWS + 1);
  localparam int RXW = ((AW > sbs_pkg::ROW_W) ? AW : sbs_pkg::ROW_W) + 1;
  localparam int CW  = NW + 11;
  localparam int CWW = sbs_pkg::SLOTS * 32;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_READ, S_RES_START, S_ROW, S_TERM, S_XWAIT, S_ACC, S_DIFF,
    S_RSQ, S_FSQ, S_FACC, S_TT, S_MH0, S_MH1, S_MH2, S_MH3, S_MH4, S_MH5,
    S_DIV, S_QOUT, S_WMUL, S_XUPD, S_DONE
  } state_t;

  state_t state;

  // configuration
  logic [8:0]  size;
  logic [7:0]  gap1, gap2;
  logic [15:0] max_iterations;
  logic [17:0] relaxation;
  logic [31:0] tolerance;

  // solver registers
  logic [NW-1:0]        i;
  logic [2:0]           k;
  logic                 res_pass, solving, rd_ok;
  logic signed [63:0]   acc;
  logic signed [63:0]   diff;
  logic signed [31:0]   xi, qv;
  logic [63:0]          rs, fs, tt;
  logic [65:0]          mid;
  logic [63:0]          quo;
  logic [32:0]          rem;
  logic [31:0]          dden;
  logic                 dneg;
  logic [5:0]           dcnt;
  logic [15:0]          sweeps;
  logic                 conv, pivot;
  logic signed [65:0]   prod;

  // memories
  logic            c_we;
  logic [AW-1:0]   c_waddr, c_raddr;
  logic [CWW-1:0]  c_wdata, c_rdata;
  logic            x_we;
  logic [AW-1:0]   x_waddr, x_raddr;
  logic [31:0]     x_wdata, x_rdata;

  sbs_ram #(.WIDTH(CWW), .DEPTH(MAX_ROWS)) u_coef_ram (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  sbs_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_x_ram (
    .clk(clk), .we(x_we), .waddr(x_waddr), .wdata(x_wdata),
    .raddr(x_raddr), .rdata(x_rdata)
  );

  // combinational helpers
  logic                 accept;
  logic [RXW-1:0]       row_x;
  logic                 row_ok;
  logic [AW-1:0]        row_idx;
  logic [NW-1:0]        n;
  logic signed [CW-1:0] col, off, o2, o3;
  logic                 col_ok;
  logic signed [31:0]   coef_k, d_coef, f_val, r_val, x_new;
  logic signed [63:0]   diff_c;
  logic signed [32:0]   mul_a, mul_b;
  logic [32:0]          rem_sh;
  logic [63:0]          hi;
  logic signed [65:0]   delta;

  assign accept  = in_valid && in_ready;
  assign in_ready = (state == S_IDLE) && !out_valid;
  assign row_x   = RXW'(row);
  assign row_ok  = row_x < RXW'(MAX_ROWS);
  assign row_idx = row_x[AW-1:0];
  assign n       = (int'(size) > MAX_ROWS) ? NW'(MAX_ROWS) : NW'(size);

  assign coef_k = c_rdata[32*k +: 32];
  assign d_coef = c_rdata[32*sbs_pkg::SLOT_MAIN +: 32];
  assign f_val  = c_rdata[32*sbs_pkg::SLOT_RHS +: 32];
  assign diff_c = sbs_pkg::sat_add64(64'(f_val) <<< FRAC_BITS, -acc);
  assign r_val  = sbs_pkg::clamp32(66'(diff >>> FRAC_BITS));
  assign rem_sh = {rem[31:0], quo[63]};
  assign hi     = prod[63:0] + 64'(mid[65:32]);
  assign delta  = prod >>> sbs_pkg::RELAX_FRAC;
  assign x_new  = sbs_pkg::clamp32(66'(xi) + delta);

  assign o2 = CW'(gap1) + CW'(2);
  assign o3 = CW'(gap1) + CW'(gap2) + CW'(3);

  always_comb begin
    case (k)
      3'd0:    off = -o3;
      3'd1:    off = -o2;
      3'd2:    off = -CW'(1);
      3'd3:    off = '0;
      3'd4:    off = CW'(1);
      3'd5:    off = o2;
      3'd6:    off = o3;
      default: off = '0;
    endcase
    col    = $signed(CW'(i)) + off;
    col_ok = !col[CW-1] && (col < $signed(CW'(n)));
  end

  always_comb begin
    c_we    = accept && (mode == sbs_pkg::MODE_LOAD) && row_ok;
    c_waddr = row_idx;
    c_wdata = {rhs_value, far_up_coef, mid_up_coef, near_up_coef, main_coef,
               near_low_coef, mid_low_coef, far_low_coef};
    c_raddr = i[AW-1:0];
    x_we    = (state == S_CLEAR) || (state == S_XUPD);
    x_waddr = i[AW-1:0];
    x_wdata = (state == S_XUPD) ? x_new : '0;
    x_raddr = (state == S_IDLE) ? row_idx : col[AW-1:0];
  end

  always_comb begin
    case (state)
      S_XWAIT: begin mul_a = 33'(coef_k);       mul_b = 33'($signed(x_rdata)); end
      S_RSQ:   begin mul_a = 33'(r_val);        mul_b = 33'(r_val);            end
      S_FSQ:   begin mul_a = 33'(f_val);        mul_b = 33'(f_val);            end
      S_TT:    begin mul_a = {1'b0, tolerance}; mul_b = {1'b0, tolerance};     end
      S_MH1:   begin mul_a = {1'b0, tt[31:0]};  mul_b = {1'b0, fs[31:0]};      end
      S_MH2:   begin mul_a = {1'b0, tt[31:0]};  mul_b = {1'b0, fs[63:32]};     end
      S_MH3:   begin mul_a = {1'b0, tt[63:32]}; mul_b = {1'b0, fs[31:0]};      end
      S_MH4:   begin mul_a = {1'b0, tt[63:32]}; mul_b = {1'b0, fs[63:32]};     end
      S_WMUL:  begin mul_a = 33'(qv);           mul_b = 33'(relaxation);       end
      default: begin mul_a = '0;                mul_b = '0;                    end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      i              <= '0;
      solving        <= 1'b0;
      sweeps         <= '0;
      conv           <= 1'b0;
      pivot          <= 1'b0;
      out_valid      <= 1'b0;
      size           <= 9'd256;
      gap1           <= '0;
      gap2           <= '0;
      max_iterations <= 16'd1000;
      relaxation     <= 18'd65536;
      tolerance      <= 32'd42950;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sbs_pkg::REG_SIZE:  size           <= cfg_data[8:0];
          sbs_pkg::REG_GAP1:  gap1           <= cfg_data[7:0];
          sbs_pkg::REG_GAP2:  gap2           <= cfg_data[7:0];
          sbs_pkg::REG_MAXIT: max_iterations <= cfg_data[15:0];
          sbs_pkg::REG_RELAX: relaxation     <= cfg_data[17:0];
          sbs_pkg::REG_TOL:   tolerance      <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          i <= i + 1'b1;
          if (i == NW'(MAX_ROWS - 1)) begin
            i     <= '0;
            state <= solving ? S_RES_START : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            x_value     <= '0;
            sweeps_done <= sweeps;
            converged   <= conv;
            zero_pivot  <= pivot;
            case (mode)
              sbs_pkg::MODE_SOLVE: begin
                sweeps  <= '0;
                pivot   <= 1'b0;
                i       <= '0;
                solving <= 1'b1;
                state   <= S_CLEAR;
              end
              sbs_pkg::MODE_READ: begin
                rd_ok <= row_ok;
                state <= S_READ;
              end
              default: out_valid <= 1'b1;
            endcase
          end
        end
        S_READ: begin
          x_value   <= rd_ok ? $signed(x_rdata) : '0;
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        S_RES_START: begin
          rs       <= '0;
          fs       <= '0;
          i        <= '0;
          res_pass <= 1'b1;
          state    <= S_ROW;
        end
        S_ROW: begin
          k   <= '0;
          acc <= '0;
          if (i < n) begin
            state <= S_TERM;
          end else if (res_pass) begin
            state <= S_TT;
          end else begin
            sweeps <= sweeps + 1'b1;
            state  <= pivot ? S_DONE : S_RES_START;
          end
        end
        S_TERM: begin
          if (col_ok) begin
            state <= S_XWAIT;
          end else if (k == 3'd6) begin
            state <= S_DIFF;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_XWAIT: begin
          if (k == 3'(sbs_pkg::SLOT_MAIN)) begin
            xi <= $signed(x_rdata);
          end
          state <= S_ACC;
        end
        S_ACC: begin
          acc <= sbs_pkg::sat_add64(acc, prod[63:0]);
          if (k == 3'd6) begin
            state <= S_DIFF;
          end else begin
            k     <= k + 1'b1;
            state <= S_TERM;
          end
        end
        S_DIFF: begin
          diff <= diff_c;
          if (res_pass) begin
            state <= S_RSQ;
          end else if (d_coef == '0) begin
            pivot <= 1'b1;
            i     <= i + 1'b1;
            state <= S_ROW;
          end else begin
            quo   <= diff_c[63] ? 64'(-diff_c) : 64'(diff_c);
            rem   <= '0;
            dden  <= d_coef[31] ? 32'(-d_coef) : 32'(d_coef);
            dneg  <= diff_c[63] ^ d_coef[31];
            dcnt  <= '0;
            state <= S_DIV;
          end
        end
        S_RSQ: state <= S_FSQ;
        S_FSQ: begin
          rs    <= sbs_pkg::usat_add64(rs, prod[63:0]);
          state <= S_FACC;
        end
        S_FACC: begin
          fs    <= sbs_pkg::usat_add64(fs, prod[63:0]);
          i     <= i + 1'b1;
          state <= S_ROW;
        end
        S_TT:  state <= S_MH0;
        S_MH0: begin
          tt    <= prod[63:0];
          state <= S_MH1;
        end
        S_MH1: state <= S_MH2;
        S_MH2: begin
          mid   <= 66'(prod[63:32]);
          state <= S_MH3;
        end
        S_MH3: begin
          mid   <= mid + 66'(prod[63:0]);
          state <= S_MH4;
        end
        S_MH4: begin
          mid   <= mid + 66'(prod[63:0]);
          state <= S_MH5;
        end
        S_MH5: begin
          conv <= (rs <= hi);
          if ((rs <= hi) || (sweeps >= max_iterations)) begin
            state <= S_DONE;
          end else begin
            i        <= '0;
            res_pass <= 1'b0;
            state    <= S_ROW;
          end
        end
        S_DIV: begin
          if (rem_sh >= {1'b0, dden}) begin
            rem <= rem_sh - {1'b0, dden};
            quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[62:0], 1'b0};
          end
          dcnt <= dcnt + 1'b1;
          if (dcnt == 6'd63) begin
            state <= S_QOUT;
          end
        end
        S_QOUT: begin
          if (!dneg) begin
            qv <= (quo > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(quo[31:0]);
          end else begin
            qv <= (quo > 64'h8000_0000) ? 32'sh8000_0000 : $signed(-quo[31:0]);
          end
          state <= S_WMUL;
        end
        S_WMUL: state <= S_XUPD;
        S_XUPD: begin
          i     <= i + 1'b1;
          state <= S_ROW;
        end
        S_DONE: begin
          solving     <= 1'b0;
          x_value     <= '0;
          sweeps_done <= sweeps;
          converged   <= conv;
          zero_pivot  <= pivot;
          out_valid   <= 1'b1;
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/sbs_checker.sv
// Port-level checks for the seven-band SOR solver, bound to its top level.
// Depends on sbs_pkg and seven_band_sor_solver_top.
`timescale 1ns / 1ps

module sbs_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [sbs_pkg::MODE_W-1:0]   mode,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [31:0]           x_value
);

  a_no_ready_while_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("request taken while a result waits");

  a_load_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && mode == sbs_pkg::MODE_LOAD) |=> out_valid)
    else $error("load request gave no result next cycle");

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready right after a request");

  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("ready during the clearing pass");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(x_value)))
    else $error("stalled result changed");

endmodule

bind seven_band_sor_solver_top sbs_checker u_sbs_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .mode(mode),
  .out_valid(out_valid), .out_ready(out_ready), .x_value(x_value)
);

### bench/tb_seven_band_sor_solver_top.sv
// Self-checking bench for seven_band_sor_solver_top: directed table, then random phases.
// Predicts results with a local SOR model or takes them from the directed table; needs sbs_pkg and the solver RTL.
`timescale 1ns / 1ps

module tb_seven_band_sor_solver_top;

  localparam logic [sbs_pkg::MODE_W-1:0] MODE_IDLE = 2'd3;
  localparam int ROWS = sbs_pkg::MAX_ROWS_DEF;
  localparam int TOTAL_REQS = 850;

  typedef struct {
    logic [sbs_pkg::MODE_W-1:0] mode;
    logic [sbs_pkg::ROW_W-1:0] row;
    logic signed [31:0] c[sbs_pkg::SLOTS];
  } request_t;

  typedef struct {
    logic signed [31:0] xv;
    logic [15:0] sw;
    logic cv;
    logic zp;
  } result_t;

  typedef struct {
    bit is_cfg;
    logic [sbs_pkg::CFG_IDX_W-1:0] idx;
    logic [sbs_pkg::DATA_W-1:0] data;
    request_t req;
    bit typed;
    result_t res;
  } step_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [sbs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [sbs_pkg::DATA_W-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic [sbs_pkg::MODE_W-1:0] mode = '0;
  logic [sbs_pkg::ROW_W-1:0] row = '0;
  logic signed [31:0] main_coef = 0, near_low_coef = 0, mid_low_coef = 0, far_low_coef = 0;
  logic signed [31:0] near_up_coef = 0, mid_up_coef = 0, far_up_coef = 0, rhs_value = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [31:0] x_value;
  logic [15:0] sweeps_done;
  logic converged;
  logic zero_pivot;

  seven_band_sor_solver_top i_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // local copy of the solver state
  logic signed [31:0] band[ROWS][sbs_pkg::SLOTS];
  logic signed [31:0] xsol[ROWS];
  bit loaded[ROWS];
  int s_size = 256, s_gap1 = 0, s_gap2 = 0, s_maxit = 1000, s_sweeps = 0;
  longint s_relax = 65536;
  logic [31:0] s_tol = 42950;
  bit s_conv = 0, s_piv = 0;

  result_t pending_q[$];
  step_t plan[$];
  int errors = 0;
  int sent = 0;
  bit calm = 0;
  bit took = 0;
  int hold = 0;
  result_t got;

  function automatic longint sadd(longint a, longint b);
    logic signed [64:0] s;
    s = a + b;
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (s < -65'sh0_7FFF_FFFF_FFFF_FFFF) return -64'sh7FFF_FFFF_FFFF_FFFF;
    return s[63:0];
  endfunction

  function automatic longint lim32(longint v);
    if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  function automatic logic [63:0] uadd(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  // f_i*2^16 - row_i . x, kept in 32 fraction bits
  function automatic longint row_gap(int i, int n);
    int o2, o3, col;
    int offs[7];
    longint s;
    o2 = s_gap1 + 2;
    o3 = s_gap1 + s_gap2 + 3;
    offs = '{-o3, -o2, -1, 0, 1, o2, o3};
    s = 0;
    for (int k = 0; k < 7; k++) begin
      col = i + offs[k];
      if (col >= 0 && col < n) s = sadd(s, longint'(band[i][k]) * longint'(xsol[col]));
    end
    return sadd(longint'(band[i][sbs_pkg::SLOT_RHS]) <<< sbs_pkg::FRAC_BITS_DEF, -s);
  endfunction

  function automatic bit residual_met(int n);
    logic [63:0] rs, fs, t2;
    logic [127:0] p;
    longint r, f;
    rs = 0;
    fs = 0;
    for (int i = 0; i < n; i++) begin
      r = lim32(row_gap(i, n) >>> sbs_pkg::FRAC_BITS_DEF);
      f = band[i][sbs_pkg::SLOT_RHS];
      rs = uadd(rs, r * r);
      fs = uadd(fs, f * f);
    end
    t2 = {32'b0, s_tol} * {32'b0, s_tol};
    p = {64'b0, t2} * {64'b0, fs};
    return rs <= p[127:64];
  endfunction

  function automatic void relax_pass(int n);
    longint d, q, delta;
    for (int i = 0; i < n; i++) begin
      d = band[i][sbs_pkg::SLOT_MAIN];
      if (d == 0) begin
        s_piv = 1;
        continue;
      end
      q = lim32(row_gap(i, n) / d);
      delta = (q * s_relax) >>> sbs_pkg::RELAX_FRAC;
      xsol[i] = lim32(longint'(xsol[i]) + delta);
    end
  endfunction

  function automatic result_t predict(request_t r);
    result_t o;
    int n;
    o.xv = 0;
    case (r.mode)
      sbs_pkg::MODE_LOAD: begin
        for (int k = 0; k < sbs_pkg::SLOTS; k++) band[r.row][k] = r.c[k];
        loaded[r.row] = 1;
      end
      sbs_pkg::MODE_SOLVE: begin
        n = (s_size > ROWS) ? ROWS : s_size;
        for (int i = 0; i < ROWS; i++) xsol[i] = 0;
        s_sweeps = 0;
        s_piv = 0;
        s_conv = residual_met(n);
        while (!s_conv && s_sweeps < s_maxit) begin
          relax_pass(n);
          s_sweeps++;
          if (s_piv) break;
          s_conv = residual_met(n);
        end
      end
      sbs_pkg::MODE_READ: o.xv = xsol[r.row];
      default: ;
    endcase
    o.sw = s_sweeps[15:0];
    o.cv = s_conv;
    o.zp = s_piv;
    return o;
  endfunction

  function automatic request_t make_req(logic [1:0] m, int r, logic [31:0] main_v,
                                        logic [31:0] off_v, logic [31:0] rhs_v);
    request_t q;
    q.mode = m;
    q.row = r[7:0];
    for (int k = 0; k < sbs_pkg::SLOTS; k++) q.c[k] = off_v;
    q.c[sbs_pkg::SLOT_MAIN] = main_v;
    q.c[sbs_pkg::SLOT_RHS] = rhs_v;
    return q;
  endfunction

  function automatic void add_cfg(logic [sbs_pkg::CFG_IDX_W-1:0] idx, logic [31:0] v);
    step_t s;
    s.is_cfg = 1;
    s.idx = idx;
    s.data = v;
    s.typed = 0;
    plan.insert(plan.size(), s);
  endfunction

  function automatic void add_req(request_t q, bit typed = 0, logic [31:0] xv = 0,
                                  logic [15:0] sw = 0, bit cv = 0, bit zp = 0);
    step_t s;
    s.is_cfg = 0;
    s.req = q;
    s.typed = typed;
    s.res.xv = xv;
    s.res.sw = sw;
    s.res.cv = cv;
    s.res.zp = zp;
    plan.insert(plan.size(), s);
  endfunction

  task automatic drain();
    while (pending_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [sbs_pkg::CFG_IDX_W-1:0] idx, logic [31:0] v);
    in_valid <= 0;
    drain();
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      sbs_pkg::REG_SIZE: s_size = v[8:0];
      sbs_pkg::REG_GAP1: s_gap1 = v[7:0];
      sbs_pkg::REG_GAP2: s_gap2 = v[7:0];
      sbs_pkg::REG_MAXIT: s_maxit = v[15:0];
      sbs_pkg::REG_RELAX: s_relax = v[17:0];
      sbs_pkg::REG_TOL: s_tol = v;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send(request_t q, bit typed, result_t typed_res);
    int gap;
    result_t e;
    gap = calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    mode <= q.mode;
    row <= q.row;
    far_low_coef <= q.c[0];
    mid_low_coef <= q.c[1];
    near_low_coef <= q.c[2];
    main_coef <= q.c[3];
    near_up_coef <= q.c[4];
    mid_up_coef <= q.c[5];
    far_up_coef <= q.c[6];
    rhs_value <= q.c[7];
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    e = predict(q);
    if (typed) e = typed_res;
    pending_q.insert(pending_q.size(), e);
    sent++;
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_small();
    return $urandom_range(0, 32767) - 16384;
  endfunction

  function automatic request_t rand_load(int r);
    request_t q;
    int pick;
    pick = $urandom_range(0, 9);
    q.mode = sbs_pkg::MODE_LOAD;
    q.row = r[7:0];
    for (int k = 0; k < sbs_pkg::SLOTS; k++) q.c[k] = (pick >= 7) ? $urandom() : rand_small();
    if (pick < 7) begin
      q.c[sbs_pkg::SLOT_MAIN] = ($urandom_range(4, 8) << 16) + $urandom_range(0, 65535);
      if ($urandom_range(0, 1)) q.c[sbs_pkg::SLOT_MAIN] = -q.c[sbs_pkg::SLOT_MAIN];
      q.c[sbs_pkg::SLOT_RHS] = $urandom_range(0, 2097151) - 1048576;
    end else if (pick == 9) begin
      q.c[sbs_pkg::SLOT_MAIN] = 0;
    end
    return q;
  endfunction

  always @(negedge clk) begin
    if (took) begin
      took = 0;
      hold = calm ? 0 : $urandom_range(0, 13);
    end
    out_ready <= (hold == 0);
    if (hold > 0) hold--;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      took = 1;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result x=%h sweeps=%0d conv=%b piv=%b", $time,
                 x_value, sweeps_done, converged, zero_pivot);
      end else begin
        got = pending_q.pop_front();
        if (got.xv !== x_value || got.sw !== sweeps_done || got.cv !== converged ||
            got.zp !== zero_pivot) begin
          errors++;
          $display("%0t: mismatch expected x=%h sweeps=%0d conv=%b piv=%b,",
                   $time, got.xv, got.sw, got.cv, got.zp,
                   " got x=%h sweeps=%0d conv=%b piv=%b",
                   x_value, sweeps_done, converged, zero_pivot);
        end
      end
    end
  end

  initial begin
    #500_000_000;
    $display("tb_seven_band_sor_solver_top: errors");
    $finish;
  end

  initial begin
    request_t q;
    int n, r, pick;
    for (int i = 0; i < ROWS; i++) begin
      xsol[i] = 0;
      loaded[i] = 0;
      for (int k = 0; k < sbs_pkg::SLOTS; k++) band[i][k] = 0;
    end

    // directed table
    add_req(make_req(sbs_pkg::MODE_READ, 0, 0, 0, 0), 1, 0, 0, 0, 0);
    add_req(make_req(MODE_IDLE, 255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
            1, 0, 0, 0, 0);
    add_req(make_req(sbs_pkg::MODE_READ, 255, 0, 0, 0), 1, 0, 0, 0, 0);
    add_cfg(sbs_pkg::REG_SIZE, 4);
    add_req(make_req(sbs_pkg::MODE_LOAD, 0, 32'h0004_0000, 32'h0000_4000, 32'h0001_0000));
    add_req(make_req(sbs_pkg::MODE_LOAD, 1, 32'hFFFC_0000, 32'hFFFF_C000, 32'hFFFF_0000));
    add_req(make_req(sbs_pkg::MODE_LOAD, 2, 32'h0004_0000, 32'h0000_4000, 32'h0002_8000));
    add_req(make_req(sbs_pkg::MODE_LOAD, 3, 32'h0008_0000, 32'h0000_4000, 32'h7FFF_FFFF));
    add_req(make_req(sbs_pkg::MODE_LOAD, 200, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    add_cfg(sbs_pkg::REG_MAXIT, 0);
    add_req(make_req(sbs_pkg::MODE_SOLVE, 0, 0, 0, 0));
    add_cfg(sbs_pkg::REG_MAXIT, 65535);
    add_cfg(sbs_pkg::REG_TOL, 32'hFFFF_FFFF);
    add_req(make_req(sbs_pkg::MODE_SOLVE, 0, 0, 0, 0));
    add_cfg(sbs_pkg::REG_MAXIT, 30);
    add_cfg(sbs_pkg::REG_TOL, 42950);
    add_req(make_req(sbs_pkg::MODE_SOLVE, 0, 0, 0, 0));
    add_req(make_req(sbs_pkg::MODE_READ, 0, 0, 0, 0));
    add_req(make_req(sbs_pkg::MODE_READ, 3, 0, 0, 0));
    add_req(make_req(sbs_pkg::MODE_READ, 200, 0, 0, 0));
    add_cfg(sbs_pkg::REG_GAP1, 252);
    add_cfg(sbs_pkg::REG_GAP2, 252);
    add_req(make_req(sbs_pkg::MODE_SOLVE, 0, 0, 0, 0));
    add_cfg(sbs_pkg::REG_RELAX, 131072);
    add_cfg(sbs_pkg::REG_TOL, 0);
    add_req(make_req(sbs_pkg::MODE_SOLVE, 0, 0, 0, 0));
    add_cfg(sbs_pkg::REG_RELAX, 0);
    add_req(make_req(sbs_pkg::MODE_SOLVE, 0, 0, 0, 0));
    // zero right-hand side passes before any sweep
    for (int i = 0; i < 4; i++)
      add_req(make_req(sbs_pkg::MODE_LOAD, i, 32'h0004_0000, 32'h0000_4000, 0));
    add_req(make_req(sbs_pkg::MODE_SOLVE, 0, 0, 0, 0), 1, 0, 0, 1, 0);
    // zero diagonal ends the solve after one sweep
    add_cfg(sbs_pkg::REG_RELAX, 65536);
    add_cfg(sbs_pkg::REG_TOL, 42950);
    add_req(make_req(sbs_pkg::MODE_LOAD, 1, 0, 32'h0000_4000, 32'h0001_0000));
    add_req(make_req(sbs_pkg::MODE_SOLVE, 0, 0, 0, 0), 1, 0, 1, 0, 1);
    add_req(make_req(sbs_pkg::MODE_LOAD, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    add_req(make_req(sbs_pkg::MODE_LOAD, 1, 32'h0004_0000, 32'h8000_0000, 32'h8000_0000));
    add_req(make_req(sbs_pkg::MODE_SOLVE, 0, 0, 0, 0));

    repeat (7) @(negedge clk);
    rst <= 0;
    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].idx, plan[i].data);
      else send(plan[i].req, plan[i].typed, plan[i].res);
    end

    // random phases
    while (sent < TOTAL_REQS) begin
      calm = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 29);
      if (pick == 0) begin
        write_reg(sbs_pkg::REG_SIZE, $urandom_range(256, 511));
        write_reg(sbs_pkg::REG_MAXIT, $urandom_range(0, 1));
      end else begin
        write_reg(sbs_pkg::REG_SIZE, $urandom_range(4, 10));
        write_reg(sbs_pkg::REG_MAXIT, $urandom_range(0, 20));
      end
      write_reg(sbs_pkg::REG_GAP1,
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 252) : $urandom_range(0, 4));
      write_reg(sbs_pkg::REG_GAP2,
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 252) : $urandom_range(0, 4));
      write_reg(sbs_pkg::REG_RELAX, ($urandom_range(0, 2) == 0) ? $urandom_range(0, 131072)
                                                                 : $urandom_range(52000, 98000));
      pick = $urandom_range(0, 9);
      write_reg(sbs_pkg::REG_TOL,
                (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom());
      n = (s_size > ROWS) ? ROWS : s_size;
      for (int j = 0; j < 40 && sent < TOTAL_REQS; j++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, n - 1);
          send(rand_load(r), 0, got);
        end else if (pick < 75) begin
          q = make_req(sbs_pkg::MODE_READ, $urandom_range(0, 255), $urandom(), $urandom(),
                       $urandom());
          send(q, 0, got);
        end else if (pick < 85) begin
          q = make_req(MODE_IDLE, $urandom_range(0, 255), $urandom(), $urandom(), $urandom());
          send(q, 0, got);
        end else begin
          for (int i = 0; i < n; i++)
            if (!loaded[i]) send(rand_load(i), 0, got);
          q = make_req(sbs_pkg::MODE_SOLVE, $urandom_range(0, 255), $urandom(), $urandom(),
                       $urandom());
          send(q, 0, got);
        end
      end
    end

    in_valid <= 0;
    drain();
    repeat (100) @(negedge clk);
    if (errors == 0) $display("tb_seven_band_sor_solver_top: clean");
    else $display("tb_seven_band_sor_solver_top: errors");
    $finish;
  end

endmodule

### filelist.f
sv/sbs_pkg.sv
sv/sbs_ram.sv
sv/seven_band_sor_solver_top.sv
sv/sbs_checker.sv
bench/tb_seven_band_sor_solver_top.sv
